// ===== rtl/sapc_pkg.sv =====
package sapc_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD     = 2'd0,
    MODE_CLAMP    = 2'd1,
    MODE_TO_PULSE = 2'd2,
    MODE_TO_ANGLE = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_WIN,
    ST_CLAMP,
    ST_START,
    ST_DIV,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        [11:0] center;
    logic               reversed;
    logic        [17:0] step;
    logic signed [15:0] lower;
    logic signed [15:0] upper;
  } entry_t;

  localparam logic [11:0]        FALLBACK_CENTER = 12'd135;
  localparam logic [17:0]        FALLBACK_STEP   = 18'd18301;
  localparam logic signed [15:0] FALLBACK_LIMIT  = 16'sd12868;

  localparam entry_t FALLBACK_ENTRY = '{
    center:   FALLBACK_CENTER,
    reversed: 1'b0,
    step:     FALLBACK_STEP,
    lower:    -FALLBACK_LIMIT,
    upper:    FALLBACK_LIMIT
  };

  // Degrees to radians for sixteenths of a degree, Q16 scaled to a Q12 result.
  localparam logic signed [19:0] MARGIN_SCALE = 20'sd292818;

  localparam int DIV_NUM_W = 25;
  localparam int DIV_DEN_W = 19;

endpackage

// ===== rtl/sapc_ram.sv =====
module sapc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sapc_div.sv =====
module sapc_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 19
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;

  assign rem_sh = {rem, quo[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NUM_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      if (!diff[DEN_W]) begin
        rem <= diff[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/servo_angle_pwm_converter.sv =====
// Servo angle and pulse converter with a calibration table of CHANNELS entries.
// Input channel: in_valid/in_ready with mode, channel and the operand fields.
// Mode 0 writes one table entry, mode 1 clamps an angle into the limits narrowed
// by a margin, mode 2 converts an angle to a pulse, mode 3 a pulse to an angle.
// Output channel: out_valid/out_ready with exactly one result item per input item.
// The block works on one item at a time and drops in_ready while it does.
// From acceptance, a load or a channel outside the table goes straight to ST_DONE;
// modes 1 and 3 pass ST_READ, ST_MUL, ST_WIN and ST_CLAMP first, and mode 2 adds
// ST_START, ST_DIV and ST_SUM, where a restoring divider yields one quotient bit
// per cycle over 25 bits.
// A finished result sits in the output register; the next item is accepted while
// it waits, and that item's result is held internally until the receiver takes
// the previous one.
// Reset empties the pipeline and marks every table entry as holding the fallback
// calibration (center 135, forward direction, one degree per step, limits of
// plus and minus pi); no clearing pass is needed.
module servo_angle_pwm_converter import sapc_pkg::*; #(
  parameter int CHANNELS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [7:0]         channel,
  input  logic signed [15:0] angle_in,
  input  logic [11:0]        pulse_in,
  input  logic [11:0]        margin,
  input  logic [11:0]        load_center,
  input  logic               load_reversed,
  input  logic [17:0]        load_step,
  input  logic signed [15:0] load_lower,
  input  logic signed [15:0] load_upper,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] angle_out,
  output logic [11:0]        pulse_out,
  output logic               channel_valid,
  output logic               saturated
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t state, state_next;

  logic             accept;
  logic             ch_ok;
  logic [IDX_W-1:0] idx;
  logic             ram_we;
  logic             div_start;
  logic             div_done;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic             out_load;

  logic [CHANNELS-1:0] written;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t           load_entry;
  entry_t           sel;

  mode_t              mode_r;
  logic signed [15:0] angle_r;
  logic [11:0]        pulse_r;
  logic [11:0]        margin_r;
  logic               hit_r;

  logic [11:0]        e_center;
  logic               e_rev;
  logic [17:0]        e_step;
  logic signed [15:0] e_lo;
  logic signed [15:0] e_hi;

  logic signed [12:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [32:0] mul_p;
  logic signed [31:0] prod;

  logic [31:0]        m_sum;
  logic [14:0]        m;
  logic signed [17:0] wlo_c;
  logic signed [17:0] whi_c;
  logic signed [15:0] wlo;
  logic signed [15:0] whi;

  logic [31:0]        p_mag;
  logic [31:0]        r_sum;
  logic [22:0]        r;
  logic signed [23:0] a_r;
  logic signed [15:0] a_clamped;
  logic signed [15:0] c_val;
  logic signed [15:0] c_r;
  logic [15:0]        c_mag;
  logic               q_neg;

  logic signed [25:0] q_s;
  logic signed [25:0] p_s;

  logic signed [15:0] res_angle;
  logic [11:0]        res_pulse;
  logic               res_valid;
  logic               res_sat;

  assign accept   = in_valid && in_ready;
  assign ch_ok    = {1'b0, channel} < 9'(CHANNELS);
  assign idx      = channel[IDX_W-1:0];
  assign ram_we   = accept && (mode_t'(mode) == MODE_LOAD) && ch_ok;
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  assign load_entry = '{
    center:   load_center,
    reversed: load_reversed,
    step:     load_step,
    lower:    load_lower,
    upper:    load_upper
  };

  sapc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CHANNELS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (load_entry),
    .re    (accept),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  sapc_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if ((mode_t'(mode) == MODE_LOAD) || !ch_ok) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_WIN;
      ST_WIN:   state_next = ST_CLAMP;
      ST_CLAMP: begin
        if (mode_r == MODE_TO_PULSE) begin
          state_next = ST_START;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM:   state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (ram_we) begin
      written[idx] <= 1'b1;
    end
  end

  assign sel = hit_r ? entry_t'(ram_rdata) : FALLBACK_ENTRY;

  assign mul_a = (mode_r == MODE_TO_ANGLE) ?
                 $signed({1'b0, pulse_r}) - $signed({1'b0, e_center}) :
                 $signed({1'b0, margin_r});
  assign mul_b = (mode_r == MODE_TO_ANGLE) ? $signed({2'b00, e_step}) : MARGIN_SCALE;
  assign mul_p = mul_a * mul_b;

  assign m_sum = prod + 32'd32768;
  assign m     = m_sum[30:16];
  assign wlo_c = {{2{e_lo[15]}}, e_lo} + $signed({3'b000, m});
  assign whi_c = {{2{e_hi[15]}}, e_hi} - $signed({3'b000, m});

  assign p_mag = prod[31] ? 32'(-prod) : prod;
  assign r_sum = p_mag + 32'd128;
  assign r     = r_sum[30:8];

  always_comb begin
    if (angle_r < wlo) begin
      c_val = wlo;
    end else if (angle_r > whi) begin
      c_val = whi;
    end else begin
      c_val = angle_r;
    end
    if (a_r < $signed({{8{e_lo[15]}}, e_lo})) begin
      a_clamped = e_lo;
    end else if (a_r > $signed({{8{e_hi[15]}}, e_hi})) begin
      a_clamped = e_hi;
    end else begin
      a_clamped = a_r[15:0];
    end
  end

  assign c_mag   = c_r[15] ? 16'(-c_r) : c_r;
  assign div_num = {c_mag, 9'b0} + DIV_NUM_W'(e_step);
  assign div_den = {e_step, 1'b0};

  assign q_s = q_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign p_s = q_s + $signed({14'b0, e_center});

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          mode_r    <= mode_t'(mode);
          angle_r   <= angle_in;
          pulse_r   <= pulse_in;
          margin_r  <= margin;
          hit_r     <= written[idx];
          res_valid <= ch_ok;
          res_sat   <= 1'b0;
          res_angle <= ((mode_t'(mode) == MODE_CLAMP) && !ch_ok) ? angle_in : 16'sd0;
          res_pulse <= ((mode_t'(mode) == MODE_TO_PULSE) && !ch_ok) ?
                       FALLBACK_CENTER : 12'd0;
        end
      end
      ST_READ: begin
        e_center <= sel.center;
        e_rev    <= sel.reversed;
        e_step   <= (sel.step == 18'd0) ? 18'd1 : sel.step;
        e_lo     <= (sel.lower < sel.upper) ? sel.lower : sel.upper;
        e_hi     <= (sel.lower < sel.upper) ? sel.upper : sel.lower;
      end
      ST_MUL: begin
        prod <= mul_p[31:0];
      end
      ST_WIN: begin
        if (wlo_c > whi_c) begin
          wlo <= e_lo;
          whi <= e_hi;
        end else begin
          wlo <= wlo_c[15:0];
          whi <= whi_c[15:0];
        end
        a_r <= (prod[31] ^ e_rev) ? -$signed({1'b0, r}) : $signed({1'b0, r});
      end
      ST_CLAMP: begin
        c_r <= c_val;
        if (mode_r == MODE_CLAMP) begin
          res_angle <= c_val;
        end else if (mode_r == MODE_TO_ANGLE) begin
          res_angle <= a_clamped;
        end
      end
      ST_START: begin
        q_neg <= c_r[15] ^ e_rev;
      end
      ST_SUM: begin
        if (p_s < 26'sd0) begin
          res_pulse <= 12'd0;
          res_sat   <= 1'b1;
        end else if (p_s > 26'sd4095) begin
          res_pulse <= 12'd4095;
          res_sat   <= 1'b1;
        end else begin
          res_pulse <= p_s[11:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      angle_out     <= res_angle;
      pulse_out     <= res_pulse;
      channel_valid <= res_valid;
      saturated     <= res_sat;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input accepted again while an item is in flight");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside its wait state");

  a_sat_at_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> ((pulse_out == 12'd0) || (pulse_out == 12'd4095)))
    else $error("saturated pulse is not at a rail");

  a_invalid_no_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !channel_valid) |-> !saturated)
    else $error("saturation flagged for a channel outside the table");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && !out_ready) |=> (state == ST_DONE))
    else $error("result left the holding state while the output stalled");

endmodule

// ===== bench/servo_angle_pwm_converter_tb.sv =====
module servo_angle_pwm_converter_tb import sapc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PER_PHASE = 256;

  typedef struct packed {
    mode_t              mode;
    logic [7:0]         channel;
    logic signed [15:0] angle;
    logic [11:0]        pulse;
    logic [11:0]        margin;
    logic [11:0]        center;
    logic               reversed;
    logic [17:0]        step;
    logic signed [15:0] lower;
    logic signed [15:0] upper;
  } servo_cmd_t;

  typedef struct packed {
    logic signed [15:0] angle;
    logic [11:0]        pulse;
    logic               valid;
    logic               sat;
  } servo_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  servo_cmd_t shown_cmd = '0;

  wire                     in_ready;
  wire                     out_valid;
  wire signed [15:0]       angle_out;
  wire [11:0]              pulse_out;
  wire                     channel_valid;
  wire                     saturated;

  servo_cmd_t    pending_cmds[$];
  servo_result_t awaited_results[$];
  entry_t        cal_table[CHANNELS];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_req = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  int  failures = 0;
  bit  in_fire = 1'b0;

  always #10 clk = ~clk;

  servo_angle_pwm_converter #(
    .CHANNELS(CHANNELS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (shown_cmd.mode),
    .channel      (shown_cmd.channel),
    .angle_in     (shown_cmd.angle),
    .pulse_in     (shown_cmd.pulse),
    .margin       (shown_cmd.margin),
    .load_center  (shown_cmd.center),
    .load_reversed(shown_cmd.reversed),
    .load_step    (shown_cmd.step),
    .load_lower   (shown_cmd.lower),
    .load_upper   (shown_cmd.upper),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .angle_out    (angle_out),
    .pulse_out    (pulse_out),
    .channel_valid(channel_valid),
    .saturated    (saturated)
  );

  function automatic longint rounded_quotient(longint num, longint den);
    if (num >= 0) begin
      return (num * 2 + den) / (den * 2);
    end
    return -((-num * 2 + den) / (den * 2));
  endfunction

  function automatic servo_result_t convert_servo(servo_cmd_t c);
    servo_result_t r;
    entry_t        e;
    longint        lo, hi, m, wlo, whi, stp, ang, q, p, a;
    r = '0;
    r.valid = (c.channel < CHANNELS);
    if (c.mode == MODE_LOAD) begin
      if (r.valid) begin
        cal_table[c.channel] = '{c.center, c.reversed, c.step, c.lower, c.upper};
      end
    end else if (!r.valid) begin
      if (c.mode == MODE_CLAMP) begin
        r.angle = c.angle;
      end else if (c.mode == MODE_TO_PULSE) begin
        r.pulse = FALLBACK_CENTER;
      end
    end else begin
      e = cal_table[c.channel];
      lo = $signed(e.lower);
      hi = $signed(e.upper);
      if (lo > hi) begin
        lo = $signed(e.upper);
        hi = $signed(e.lower);
      end
      stp = (e.step == 0) ? 1 : longint'(e.step);
      if (c.mode == MODE_TO_ANGLE) begin
        a = (longint'(c.pulse) - longint'(e.center)) * stp;
        if (e.reversed) begin
          a = -a;
        end
        a = rounded_quotient(a, 256);
        if (a < lo) a = lo;
        if (a > hi) a = hi;
        r.angle = a[15:0];
      end else begin
        m = (longint'(c.margin) * longint'(MARGIN_SCALE) + 32768) >>> 16;
        wlo = lo + m;
        whi = hi - m;
        if (wlo > whi) begin
          wlo = lo;
          whi = hi;
        end
        ang = $signed(c.angle);
        if (ang < wlo) ang = wlo;
        if (ang > whi) ang = whi;
        if (c.mode == MODE_CLAMP) begin
          r.angle = ang[15:0];
        end else begin
          q = rounded_quotient(ang * 256, stp);
          if (e.reversed) begin
            q = -q;
          end
          p = longint'(e.center) + q;
          if (p < 0) begin
            p = 0;
            r.sat = 1'b1;
          end else if (p > 4095) begin
            p = 4095;
            r.sat = 1'b1;
          end
          r.pulse = p[11:0];
        end
      end
    end
    return r;
  endfunction

  function automatic servo_cmd_t random_cmd();
    servo_cmd_t c;
    int         pick;
    c.channel = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(CHANNELS - 1));
    pick = $urandom_range(99);
    c.mode = (pick < 12) ? MODE_LOAD : (pick < 40) ? MODE_CLAMP :
             (pick < 70) ? MODE_TO_PULSE : MODE_TO_ANGLE;
    c.angle = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(32767) - 16384);
    c.pulse = 12'($urandom);
    c.margin = ($urandom_range(7) == 0) ? 12'($urandom) : 12'($urandom_range(2880));
    c.center = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(3000, 1000));
    c.reversed = 1'($urandom);
    pick = $urandom_range(31);
    c.step = (pick == 0) ? 18'd0 : (pick < 9) ? 18'($urandom) : 18'($urandom_range(40000, 100));
    c.lower = 16'($urandom);
    c.upper = 16'($urandom);
    return c;
  endfunction

  task automatic push_op(mode_t m, int ch, int ang, int pul, int mar);
    servo_cmd_t c;
    c = random_cmd();
    c.mode = m;
    c.channel = ch[7:0];
    c.angle = ang[15:0];
    c.pulse = pul[11:0];
    c.margin = mar[11:0];
    pending_cmds.push_back(c);
  endtask

  task automatic push_load(int ch, int ctr, bit rev, int stp, int lwr, int upr);
    servo_cmd_t c;
    c = random_cmd();
    c.mode = MODE_LOAD;
    c.channel = ch[7:0];
    c.center = ctr[11:0];
    c.reversed = rev;
    c.step = stp[17:0];
    c.lower = lwr[15:0];
    c.upper = upr[15:0];
    pending_cmds.push_back(c);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_valid || awaited_results.size() != 0);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        shown_cmd <= pending_cmds.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_served != hold_req) begin
      hold_served <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    servo_result_t want;
    in_fire = !rst && in_valid && in_ready;
    if (in_fire) begin
      awaited_results.push_back(convert_servo(shown_cmd));
    end
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result item arrived with no command awaiting it");
        failures++;
      end else begin
        want = awaited_results.pop_front();
        if (angle_out !== want.angle) begin
          $error("angle_out expected %0d actual %0d", want.angle, angle_out);
          failures++;
        end
        if (pulse_out !== want.pulse) begin
          $error("pulse_out expected %0d actual %0d", want.pulse, pulse_out);
          failures++;
        end
        if (channel_valid !== want.valid) begin
          $error("channel_valid expected %0b actual %0b", want.valid, channel_valid);
          failures++;
        end
        if (saturated !== want.sat) begin
          $error("saturated expected %0b actual %0b", want.sat, saturated);
          failures++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      cal_table[i] = FALLBACK_ENTRY;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items run against the fallback calibration first.
    push_op(MODE_CLAMP, 0, 32767, 0, 0);
    push_op(MODE_CLAMP, 1, -32768, 0, 160);
    push_op(MODE_CLAMP, 0, 20000, 0, 2880);
    push_op(MODE_CLAMP, 0, 20000, 0, 2881);
    push_op(MODE_TO_PULSE, 2, 12868, 0, 0);
    push_op(MODE_TO_PULSE, 0, -32768, 0, 0);
    push_op(MODE_TO_ANGLE, 3, 0, 4095, 0);
    push_op(MODE_TO_ANGLE, 3, 0, 0, 0);
    push_load(16, 777, 1'b1, 5, -5, 5);
    push_op(MODE_CLAMP, 255, -1234, 0, 0);
    push_op(MODE_TO_PULSE, 16, 500, 0, 0);
    push_op(MODE_TO_ANGLE, 200, 0, 77, 0);
    push_load(15, 4095, 1'b1, 0, 32767, -32768);
    push_op(MODE_TO_PULSE, 15, -32768, 0, 0);
    push_op(MODE_TO_PULSE, 15, 32767, 0, 0);
    push_op(MODE_TO_ANGLE, 15, 0, 0, 0);
    push_op(MODE_CLAMP, 15, 20000, 0, 4095);
    push_load(1, 2048, 1'b0, 512, -32768, 32767);
    push_op(MODE_TO_PULSE, 1, 1, 0, 0);
    push_op(MODE_TO_PULSE, 1, -1, 0, 0);
    push_load(2, 0, 1'b0, 128, -4, 4);
    push_op(MODE_TO_ANGLE, 2, 0, 1, 0);
    push_load(3, 100, 1'b0, 262143, -32768, 32767);
    push_op(MODE_TO_ANGLE, 3, 0, 4095, 0);
    push_op(MODE_TO_PULSE, 3, -32768, 0, 0);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 62 : (phase == 3) ? 36 : 0;
      recv_stall_pct = (phase == 2) ? 62 : (phase == 3) ? 36 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pending_cmds.push_back(random_cmd());
      end
      // The receiver holds off while the sender keeps offering items.
      if (phase == 0) begin
        repeat (20) @(posedge clk);
        hold_req++;
      end
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
